// ===== rtl/core/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// shared types and constants of the chained hash map core
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CFG_BITS   = 9;
   localparam int COUNT_BITS = 11;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_UPDATED   = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_POOL_FULL = 3'd3,
      ST_DONE      = 3'd4
   } status_type;

   typedef struct packed {
      op_type                  opcode;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [VALUE_BITS-1:0]   read_value;
      logic [KEY_BITS-1:0]     stored_key;
      status_type              status;
      logic [COUNT_BITS-1:0]   entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HEAD,
      BK_ISSUE,
      BK_CMP,
      BK_POP
   } back_state_type;

endpackage

// ===== rtl/core/chained_hash_map_core.sv =====
// front: one remainder bit per cycle over the upper 30 key bits, then the queue
// push, held while the queue is full; back: a bucket head read, an issue and a
// compare step per chain entry up to a hit or the chain end, a pop step to reuse
// a freed entry; front and back overlap through a two-entry queue, but the front
// takes a new request only after its push; long chains make the back the limit
// reset: synchronous, clears all buckets, the free pool and the entry count
// ----------------------------------------------------------------------------
// chained_hash_map_core
// key/value map with separate chaining over a fixed entry pool
// ----------------------------------------------------------------------------
module chained_hash_map_core #(
   parameter int MAX_BUCKETS  = 256,
   parameter int POOL_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  chm_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output chm_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [chm_pkg::CFG_BITS-1:0]  csr_data
);
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int QW = $bits(chm_pkg::req_type) + BW;

   logic [chm_pkg::CFG_BITS-1:0]  bucket_count_ff;
   logic                          q_push;
   logic                          q_full;
   logic                          q_pop;
   logic                          q_valid;
   chm_pkg::req_type              f_work;
   logic [BW-1:0]                 f_bucket;
   chm_pkg::req_type              b_work;
   logic [BW-1:0]                 b_bucket;
   logic [QW-1:0]                 q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= '0;
      end else if (csr_valid) begin
         bucket_count_ff <= csr_data;
      end
   end

   chm_front #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .q_push       (q_push),
      .q_full       (q_full),
      .q_work       (f_work),
      .q_bucket     (f_bucket)
   );

   chm_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_bucket, f_work}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   assign b_work   = q_out[$bits(chm_pkg::req_type)-1:0];
   assign b_bucket = q_out[QW-1:$bits(chm_pkg::req_type)];

   chm_back #(
      .MAX_BUCKETS  (MAX_BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_work      (b_work),
      .q_bucket    (b_bucket),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found && rsp_payload.status == chm_pkg::ST_DONE
      |-> rsp_payload.entry_count == '0)
      else $error("clear left entries counted");

   a_insert_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == chm_pkg::ST_INSERTED |-> !rsp_payload.found)
      else $error("insert reported an existing key");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

endmodule

// ===== rtl/core/chm_front.sv =====
// ----------------------------------------------------------------------------
// chm_front
// accepts transactions and computes the bucket with a serial remainder unit
// ----------------------------------------------------------------------------
module chm_front #(
   parameter int MAX_BUCKETS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [chm_pkg::CFG_BITS-1:0]      bucket_count,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  chm_pkg::req_type                  req_payload,
   output logic                              q_push,
   input  logic                              q_full,
   output chm_pkg::req_type                  q_work,
   output logic [$clog2(MAX_BUCKETS)-1:0]    q_bucket
);
   localparam int BW   = $clog2(MAX_BUCKETS);
   localparam int NW   = $clog2(MAX_BUCKETS + 1);
   localparam int DW   = (NW > chm_pkg::CFG_BITS) ? NW : chm_pkg::CFG_BITS;
   localparam int DVW  = chm_pkg::KEY_BITS - 2;
   localparam int CNTW = $clog2(DVW + 1);

   logic                busy_ff, busy_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       div_ff, div_in;
   logic [DVW-1:0]      dvd_ff, dvd_in;
   chm_pkg::req_type    item_ff, item_in;
   logic [DW-1:0]       cfg_ext;
   logic [DW-1:0]       n_eff;
   logic [DW:0]         trial;
   logic                accept;

   assign cfg_ext   = DW'(bucket_count);
   assign n_eff     = (cfg_ext == '0 || cfg_ext > DW'(MAX_BUCKETS)) ? DW'(MAX_BUCKETS)
                                                                     : cfg_ext;
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign trial     = {rem_ff, dvd_ff[DVW-1]};
   assign q_push    = busy_ff && (cnt_ff == '0) && !q_full;
   assign q_work    = item_ff;
   assign q_bucket  = rem_ff[BW-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      item_in = item_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DVW);
         rem_in  = '0;
         div_in  = n_eff;
         dvd_in  = req_payload.key[chm_pkg::KEY_BITS-1:2];
         item_in = req_payload;
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
      end else if (q_push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      dvd_ff  <= dvd_in;
      item_ff <= item_in;
   end

endmodule

// ===== rtl/core/chm_queue.sv =====
// ----------------------------------------------------------------------------
// chm_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module chm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff ^ push;
      rd_in   = rd_ff ^ pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/chm_back.sv =====
// ----------------------------------------------------------------------------
// chm_back
// walks bucket chains in the entry memories and applies each operation
// ----------------------------------------------------------------------------
module chm_back #(
   parameter int MAX_BUCKETS  = 256,
   parameter int POOL_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  chm_pkg::req_type                  q_work,
   input  logic [$clog2(MAX_BUCKETS)-1:0]    q_bucket,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output chm_pkg::rsp_type                  rsp_payload
);
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int AW = $clog2(POOL_ENTRIES);
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam logic [LW-1:0] NONE = LW'(POOL_ENTRIES);

   logic [LW-1:0]                   head_mem [MAX_BUCKETS];
   logic [chm_pkg::KEY_BITS-1:0]    key_mem  [POOL_ENTRIES];
   logic [chm_pkg::VALUE_BITS-1:0]  val_mem  [POOL_ENTRIES];
   logic [LW-1:0]                   link_mem [POOL_ENTRIES];
   logic [AW-1:0]                   stk_mem  [POOL_ENTRIES];

   chm_pkg::back_state_type         state_ff, state_in;
   logic [MAX_BUCKETS-1:0]          hvalid_ff, hvalid_in;
   logic [LW-1:0]                   count_ff, count_in;
   logic [LW-1:0]                   sp_ff, sp_in;
   logic [LW-1:0]                   fresh_ff, fresh_in;
   logic [LW-1:0]                   cur_ff, cur_in;
   logic [LW-1:0]                   prev_ff, prev_in;
   logic [LW-1:0]                   head_ff, head_in;
   chm_pkg::req_type                work_ff, work_in;
   logic [BW-1:0]                   bkt_ff, bkt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   chm_pkg::rsp_type                rsp_ff, rsp_in;

   logic [LW-1:0]                   head_rd_ff;
   logic                            hv_rd_ff;
   logic [chm_pkg::KEY_BITS-1:0]    key_rd_ff;
   logic [chm_pkg::VALUE_BITS-1:0]  val_rd_ff;
   logic [LW-1:0]                   link_rd_ff;
   logic [AW-1:0]                   stk_rd_ff;

   logic                            out_free;
   logic                            finish;
   logic                            ins;
   logic [AW-1:0]                   ins_idx;
   logic                            head_we;
   logic [LW-1:0]                   head_wd;
   logic                            val_we;
   logic [AW-1:0]                   val_wa;
   logic                            link_we;
   logic [AW-1:0]                   link_wa;
   logic [LW-1:0]                   link_wd;
   logic                            stk_we;
   logic [AW-1:0]                   stk_ra;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign stk_ra      = AW'(sp_ff - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chm_pkg::BK_IDLE: begin
            if (q_valid && out_free && q_work.opcode != chm_pkg::OP_CLEAR) begin
               state_in = chm_pkg::BK_HEAD;
            end
         end
         chm_pkg::BK_HEAD: begin
            state_in = chm_pkg::BK_ISSUE;
         end
         chm_pkg::BK_ISSUE: begin
            if (cur_ff != NONE) begin
               state_in = chm_pkg::BK_CMP;
            end else if (work_ff.opcode == chm_pkg::OP_SET && count_ff != NONE
                         && sp_ff != '0) begin
               state_in = chm_pkg::BK_POP;
            end else begin
               state_in = chm_pkg::BK_IDLE;
            end
         end
         chm_pkg::BK_CMP: begin
            if (key_rd_ff == work_ff.key) begin
               state_in = chm_pkg::BK_IDLE;
            end else begin
               state_in = chm_pkg::BK_ISSUE;
            end
         end
         chm_pkg::BK_POP: begin
            state_in = chm_pkg::BK_IDLE;
         end
         default: begin
            state_in = chm_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop     = 1'b0;
      finish    = 1'b0;
      ins       = 1'b0;
      ins_idx   = fresh_ff[AW-1:0];
      head_we   = 1'b0;
      head_wd   = link_rd_ff;
      val_we    = 1'b0;
      val_wa    = cur_ff[AW-1:0];
      link_we   = 1'b0;
      link_wa   = prev_ff[AW-1:0];
      link_wd   = link_rd_ff;
      stk_we    = 1'b0;
      hvalid_in = hvalid_ff;
      count_in  = count_ff;
      sp_in     = sp_ff;
      fresh_in  = fresh_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      head_in   = head_ff;
      work_in   = work_ff;
      bkt_in    = bkt_ff;
      rsp_in    = rsp_ff;
      rsp_in.found      = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.stored_key = '0;
      rsp_in.status     = chm_pkg::ST_NOT_FOUND;
      unique case (state_ff)
         chm_pkg::BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop   = 1'b1;
               work_in = q_work;
               bkt_in  = q_bucket;
               if (q_work.opcode == chm_pkg::OP_CLEAR) begin
                  hvalid_in     = '0;
                  count_in      = '0;
                  sp_in         = '0;
                  fresh_in      = '0;
                  finish        = 1'b1;
                  rsp_in.status = chm_pkg::ST_DONE;
               end
            end
         end
         chm_pkg::BK_HEAD: begin
            head_in = hv_rd_ff ? head_rd_ff : NONE;
            cur_in  = hv_rd_ff ? head_rd_ff : NONE;
            prev_in = NONE;
         end
         chm_pkg::BK_ISSUE: begin
            if (cur_ff == NONE) begin
               if (work_ff.opcode != chm_pkg::OP_SET) begin
                  finish = 1'b1;
               end else if (count_ff == NONE) begin
                  finish        = 1'b1;
                  rsp_in.status = chm_pkg::ST_POOL_FULL;
               end else if (sp_ff == '0) begin
                  ins      = 1'b1;
                  ins_idx  = fresh_ff[AW-1:0];
                  fresh_in = fresh_ff + 1'b1;
               end
            end
         end
         chm_pkg::BK_CMP: begin
            if (key_rd_ff == work_ff.key) begin
               finish       = 1'b1;
               rsp_in.found = 1'b1;
               case (work_ff.opcode)
                  chm_pkg::OP_SET: begin
                     val_we        = 1'b1;
                     rsp_in.status = chm_pkg::ST_UPDATED;
                  end
                  chm_pkg::OP_LOOKUP: begin
                     rsp_in.read_value = val_rd_ff;
                     rsp_in.stored_key = key_rd_ff;
                     rsp_in.status     = chm_pkg::ST_UPDATED;
                  end
                  default: begin
                     if (prev_ff == NONE) begin
                        head_we = 1'b1;
                     end else begin
                        link_we = 1'b1;
                     end
                     stk_we        = 1'b1;
                     sp_in         = sp_ff + 1'b1;
                     count_in      = count_ff - 1'b1;
                     rsp_in.status = chm_pkg::ST_DONE;
                  end
               endcase
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rd_ff;
            end
         end
         chm_pkg::BK_POP: begin
            ins     = 1'b1;
            ins_idx = stk_rd_ff;
            sp_in   = sp_ff - 1'b1;
         end
         default: begin
         end
      endcase
      if (ins) begin
         finish             = 1'b1;
         head_we            = 1'b1;
         head_wd            = LW'(ins_idx);
         hvalid_in[bkt_ff]  = 1'b1;
         val_we             = 1'b1;
         val_wa             = ins_idx;
         link_we            = 1'b1;
         link_wa            = ins_idx;
         link_wd            = head_ff;
         count_in           = count_ff + 1'b1;
         rsp_in.status      = chm_pkg::ST_INSERTED;
      end
      rsp_in.entry_count = chm_pkg::COUNT_BITS'(count_in);
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chm_pkg::BK_IDLE;
         hvalid_ff    <= '0;
         count_ff     <= '0;
         sp_ff        <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hvalid_ff    <= hvalid_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      head_ff <= head_in;
      work_ff <= work_in;
      bkt_ff  <= bkt_in;
      rsp_ff  <= rsp_in;
   end

   // bucket heads
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bkt_ff] <= head_wd;
      end
      head_rd_ff <= head_mem[q_bucket];
      hv_rd_ff   <= hvalid_ff[q_bucket];
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (ins) begin
         key_mem[ins_idx] <= work_ff.key;
      end
      key_rd_ff <= key_mem[cur_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= work_ff.value;
      end
      val_rd_ff <= val_mem[cur_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[cur_ff[AW-1:0]];
   end

   // free stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[sp_ff[AW-1:0]] <= cur_ff[AW-1:0];
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

endmodule
